@@ hw/rtl/pmss_pkg.sv @@
// pmss_pkg: shared types and address-map constants for the memory stage.
// No dependencies; imported by every module of the block.
package pmss_pkg;

  localparam logic [31:0] DATA_BASE  = 32'h1001_0000;
  localparam logic [31:0] DATA_LIMIT = 32'h1003_FFFF;
  localparam logic [31:0] STACK_TOP  = 32'h7FFF_F61C;

  typedef struct packed {
    logic [31:0] effective_address;
    logic [31:0] store_word;
    logic [4:0]  source_reg;
    logic        is_load;
    logic        is_store;
    logic        load_to_reg;
    logic        writes_reg;
    logic [4:0]  dest_reg;
    logic        is_syscall;
  } in_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

@@ hw/rtl/pmss_if.sv @@
// pmss_in_if / pmss_out_if: valid/ready channels of the memory stage.
// No dependencies.
interface pmss_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] effective_address;
  logic [31:0] store_word;
  logic [4:0]  source_reg;
  logic        is_load;
  logic        is_store;
  logic        load_to_reg;
  logic        writes_reg;
  logic [4:0]  dest_reg;
  logic        is_syscall;

  modport source (
    output valid, effective_address, store_word, source_reg, is_load, is_store,
           load_to_reg, writes_reg, dest_reg, is_syscall,
    input  ready
  );
  modport sink (
    input  valid, effective_address, store_word, source_reg, is_load, is_store,
           load_to_reg, writes_reg, dest_reg, is_syscall,
    output ready
  );
endinterface

interface pmss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] wb_alu_value;
  logic [31:0] wb_load_data;
  logic        wb_load_to_reg;
  logic        wb_writes_reg;
  logic [4:0]  wb_dest_reg;
  logic        wb_is_syscall;
  logic        wb_is_load;
  logic        address_fault;
  logic        store_forwarded;

  modport source (
    output valid, wb_alu_value, wb_load_data, wb_load_to_reg, wb_writes_reg,
           wb_dest_reg, wb_is_syscall, wb_is_load, address_fault, store_forwarded,
    input  ready
  );
  modport sink (
    input  valid, wb_alu_value, wb_load_data, wb_load_to_reg, wb_writes_reg,
           wb_dest_reg, wb_is_syscall, wb_is_load, address_fault, store_forwarded,
    output ready
  );
endinterface

@@ hw/rtl/pmss_addr_map.sv @@
// pmss_addr_map: maps a byte address onto the local byte store (data and stack regions).
// Depends on pmss_pkg.
module pmss_addr_map import pmss_pkg::*; #(
  parameter int unsigned MEM_BYTES  = 262144,
  parameter int unsigned STACK_SPAN = 8192,
  localparam int unsigned IDX_W     = $clog2(MEM_BYTES)
) (
  input  logic [31:0]      addr,
  output logic             hit,
  output logic [IDX_W-1:0] idx
);

  logic        in_data;
  logic        in_stack;
  logic [31:0] top_gap;
  logic [31:0] idx_full;

  always_comb begin
    top_gap  = STACK_TOP - addr;
    in_data  = (addr >= DATA_BASE) && (addr < DATA_LIMIT);
    in_stack = (addr <= STACK_TOP) && (top_gap <= 32'(STACK_SPAN));
    idx_full = in_data ? (addr - DATA_BASE) : (32'(STACK_SPAN) - top_gap);
    hit      = (in_data || in_stack) && (idx_full <= 32'(MEM_BYTES - 4));
    idx      = idx_full[IDX_W-1:0];
  end

endmodule

@@ hw/rtl/pmss_mem_lanes.sv @@
// pmss_mem_lanes: byte store as four byte-lane RAMs, one unaligned word per beat.
// Depends on pmss_pkg.
module pmss_mem_lanes import pmss_pkg::*; #(
  parameter int unsigned ROWS   = 65536,
  localparam int unsigned ROW_W = $clog2(ROWS)
) (
  input  logic                 clk,
  input  mem_ctl_t             ctl,
  input  logic [ROW_W-1:0]     base_row,
  input  logic [1:0]           off,
  input  logic [3:0][7:0]      wdata,
  output logic [3:0][7:0]      lane_q
);

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [7:0]       ram [ROWS];
    logic [7:0]       q_r;
    logic [1:0]       sel;
    logic [ROW_W-1:0] lane_row;

    // lanes below the offset hold the tail of the word in the next row
    assign sel      = 2'(g) - off;
    assign lane_row = base_row + ROW_W'(2'(g) < off);
    assign lane_q[g] = q_r;

    always_ff @(posedge clk) begin
      if (ctl.wr_en) begin
        ram[lane_row] <= wdata[sel];
      end
      if (ctl.rd_en) begin
        q_r <= ram[lane_row];
      end
    end
  end

endmodule

@@ hw/rtl/pipeline_memory_stage_store_forward.sv @@
// pipeline_memory_stage_store_forward: top level of the pipeline memory stage.
// Depends on pmss_pkg, pmss_if, pmss_addr_map and pmss_mem_lanes.
//
// Usage:
//   in_bus carries one instruction's EX/MEM fields per beat; out_bus returns
//   one MEM/WB beat per input beat, in order. Both use valid/ready.
//   Output valid rises when a beat moves from the input register to the
//   output register: an input register, then the address map, forwarding
//   mux and byte-lane RAM access, then the output register that also holds
//   the registered RAM read. Throughput is one beat per cycle while out_bus
//   does not stall; the four byte-lane RAMs (one address shared by read and
//   write each) serve any unaligned word in a single access.
//   Store data is taken from the last loaded word when the previous beat was
//   a load into the store's rt (register zero excluded). A beat that is both
//   store and load returns the stored word. Loads and stores whose addresses
//   lie outside the data and stack regions raise address_fault and access nothing.
//   Reset clears the pipeline valids, the last loaded word and the previous
//   beat's load tracking; the byte store is not cleared and needs no pass.
//   When out_bus stalls, the output beat holds; one more input beat is taken
//   into the input register only while it is empty, then in_bus.ready drops.
module pipeline_memory_stage_store_forward import pmss_pkg::*; #(
  parameter int unsigned MEM_BYTES  = 262144,
  parameter int unsigned STACK_SPAN = 8192
) (
  input logic        clk,
  input logic        rst_n,
  pmss_in_if.sink    in_bus,
  pmss_out_if.source out_bus
);

  localparam int unsigned IDX_W = $clog2(MEM_BYTES);
  localparam int unsigned ROWS  = (MEM_BYTES + 3) / 4;
  localparam int unsigned ROW_W = $clog2(ROWS);

  in_item_t          s1_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic              adv;

  logic              hit;
  logic [IDX_W-1:0]  idx;
  logic              fault;
  logic              fwd;
  logic [31:0]       cur_load;
  logic [31:0]       sdata;
  logic [31:0]       assembled;
  mem_ctl_t          mem_ctl;
  logic [3:0][7:0]   lane_q;

  logic [31:0]       alu_r;
  logic              load_to_reg_r;
  logic              writes_reg_r;
  logic [4:0]        dest_r;
  logic              syscall_r;
  logic              is_load_r;
  logic              is_store_r;
  logic              fault_r;
  logic              fwd_r;
  logic              loaded_r;
  logic [31:0]       sdata_r;
  logic [1:0]        off_r;
  logic [31:0]       last_r;

  assign adv          = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_r.effective_address <= in_bus.effective_address;
      s1_r.store_word        <= in_bus.store_word;
      s1_r.source_reg        <= in_bus.source_reg;
      s1_r.is_load           <= in_bus.is_load;
      s1_r.is_store          <= in_bus.is_store;
      s1_r.load_to_reg       <= in_bus.load_to_reg;
      s1_r.writes_reg        <= in_bus.writes_reg;
      s1_r.dest_reg          <= in_bus.dest_reg;
      s1_r.is_syscall        <= in_bus.is_syscall;
    end
  end

  pmss_addr_map #(
    .MEM_BYTES  (MEM_BYTES),
    .STACK_SPAN (STACK_SPAN)
  ) u_map (
    .addr (s1_r.effective_address),
    .hit  (hit),
    .idx  (idx)
  );

  // word read back from the lanes, rotated by the byte offset
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      assembled[8*k +: 8] = lane_q[2'(off_r + 2'(k))];
    end
  end

  // last loaded word after the most recent beat in the output register
  assign cur_load = !loaded_r ? last_r : (is_store_r ? sdata_r : assembled);

  always_comb begin
    fault = (s1_r.is_load || s1_r.is_store) && !hit;
    fwd   = s1_r.is_store && is_load_r && (dest_r != 5'd0)
            && (s1_r.source_reg == dest_r);
    sdata = fwd ? cur_load : s1_r.store_word;
    mem_ctl.wr_en = adv && s1_r.is_store && !fault;
    mem_ctl.rd_en = adv && s1_r.is_load && !fault;
  end

  pmss_mem_lanes #(
    .ROWS (ROWS)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .base_row (ROW_W'(idx[IDX_W-1:2])),
    .off      (idx[1:0]),
    .wdata    (sdata),
    .lane_q   (lane_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      loaded_r    <= 1'b0;
      last_r      <= 32'd0;
      is_load_r   <= 1'b0;
      dest_r      <= 5'd0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      loaded_r    <= s1_r.is_load && !fault;
      last_r      <= cur_load;
      is_load_r   <= s1_r.is_load;
      dest_r      <= s1_r.dest_reg;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alu_r         <= s1_r.effective_address;
      load_to_reg_r <= s1_r.load_to_reg;
      writes_reg_r  <= s1_r.writes_reg;
      syscall_r     <= s1_r.is_syscall;
      is_store_r    <= s1_r.is_store;
      fault_r       <= fault;
      fwd_r         <= fwd;
      sdata_r       <= sdata;
      off_r         <= idx[1:0];
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.wb_alu_value    = alu_r;
  assign out_bus.wb_load_data    = cur_load;
  assign out_bus.wb_load_to_reg  = load_to_reg_r;
  assign out_bus.wb_writes_reg   = writes_reg_r;
  assign out_bus.wb_dest_reg     = dest_r;
  assign out_bus.wb_is_syscall   = syscall_r;
  assign out_bus.wb_is_load      = is_load_r;
  assign out_bus.address_fault   = fault_r;
  assign out_bus.store_forwarded = fwd_r;

  a_fault_needs_access: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fault_r) |-> (is_load_r || is_store_r))
    else $error("address fault on a beat without memory access");

  a_load_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !s1_r.is_load) |=> (cur_load == $past(cur_load)))
    else $error("load data changed on a non-load beat");

  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (s1_valid_r && out_valid_r && !out_bus.ready))
    else $error("input stalled without a full, stalled pipeline");

endmodule
